FILE: src/slu_pkg.sv
`timescale 1ns / 1ps
package slu_pkg;

	localparam int unsigned CP_W   = 21;
	localparam int unsigned BYTE_W = 8;

	// Characters of interest
	localparam logic [CP_W-1:0] CH_QUOTE     = 21'h00_0022;
	localparam logic [CP_W-1:0] CH_BACKSLASH = 21'h00_005C;
	localparam logic [CP_W-1:0] CH_A         = 21'h00_0061;
	localparam logic [CP_W-1:0] CH_B         = 21'h00_0062;
	localparam logic [CP_W-1:0] CH_F         = 21'h00_0066;
	localparam logic [CP_W-1:0] CH_N         = 21'h00_006E;
	localparam logic [CP_W-1:0] CH_R         = 21'h00_0072;
	localparam logic [CP_W-1:0] CH_T         = 21'h00_0074;
	localparam logic [CP_W-1:0] CH_V         = 21'h00_0076;

	typedef enum logic [1:0] {
		KIND_CONTENT = 2'd0,
		KIND_DONE    = 2'd1,
		KIND_ERROR   = 2'd2
	} kind_t;

	// One input item's worth of output bytes
	typedef struct packed {
		logic                   emit;
		kind_t                  kind;
		logic [1:0]             last_idx;
		logic [3:0][BYTE_W-1:0] bytes;
	} grp_t;

	function automatic logic [CP_W-1:0] map_escape(input logic [CP_W-1:0] cp);
		logic [CP_W-1:0] r;
		r = cp;
		case (cp)
			CH_A:    r = 21'd7;
			CH_B:    r = 21'd8;
			CH_F:    r = 21'd12;
			CH_N:    r = 21'd10;
			CH_R:    r = 21'd13;
			CH_T:    r = 21'd9;
			CH_V:    r = 21'd11;
			default: r = cp;
		endcase
		return r;
	endfunction

	// Plain UTF-8 bit pattern, no range check; byte 0 goes out first
	function automatic grp_t utf8_pack(input logic [CP_W-1:0] cp);
		grp_t g;
		g.emit  = 1'b1;
		g.kind  = KIND_CONTENT;
		g.bytes = '0;
		if (cp[20:7] == '0) begin
			g.last_idx = 2'd0;
			g.bytes[0] = {1'b0, cp[6:0]};
		end else if (cp[20:11] == '0) begin
			g.last_idx = 2'd1;
			g.bytes[0] = {3'b110, cp[10:6]};
			g.bytes[1] = {2'b10, cp[5:0]};
		end else if (cp[20:16] == '0) begin
			g.last_idx = 2'd2;
			g.bytes[0] = {4'b1110, cp[15:12]};
			g.bytes[1] = {2'b10, cp[11:6]};
			g.bytes[2] = {2'b10, cp[5:0]};
		end else begin
			g.last_idx = 2'd3;
			g.bytes[0] = {5'b11110, cp[20:18]};
			g.bytes[1] = {2'b10, cp[17:12]};
			g.bytes[2] = {2'b10, cp[11:6]};
			g.bytes[3] = {2'b10, cp[5:0]};
		end
		return g;
	endfunction

endpackage

FILE: src/slu_if.sv
`timescale 1ns / 1ps
interface slu_in_if import slu_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [CP_W-1:0] code_point;
	logic            end_of_input;

	modport source (output valid, code_point, end_of_input, input ready);
	modport sink   (input valid, code_point, end_of_input, output ready);
endinterface

interface slu_out_if import slu_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        kind;
	logic [BYTE_W-1:0] data_byte;
	logic              last;

	modport source (output valid, kind, data_byte, last, input ready);
	modport sink   (input valid, kind, data_byte, last, output ready);
endinterface

FILE: src/slu_decode.sv
`timescale 1ns / 1ps
module slu_decode import slu_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [CP_W-1:0] code_point,
	input  logic            end_of_input,
	output grp_t            grp
);

	logic inside_q, esc_q;
	logic inside_d, esc_d;

	always_comb begin
		inside_d      = inside_q;
		esc_d         = esc_q;
		grp.emit      = 1'b0;
		grp.kind      = KIND_ERROR;
		grp.last_idx  = 2'd0;
		grp.bytes     = '0;
		if (!inside_q) begin
			if (!end_of_input && code_point == CH_QUOTE) begin
				inside_d = 1'b1;
				esc_d    = 1'b0;
			end else begin
				grp.emit = 1'b1;
			end
		end else if (end_of_input) begin
			inside_d = 1'b0;
			esc_d    = 1'b0;
			grp.emit = 1'b1;
		end else if (esc_q) begin
			esc_d = 1'b0;
			grp   = utf8_pack(map_escape(code_point));
		end else if (code_point == CH_BACKSLASH) begin
			esc_d = 1'b1;
		end else if (code_point == CH_QUOTE) begin
			inside_d = 1'b0;
			grp.emit = 1'b1;
			grp.kind = KIND_DONE;
		end else begin
			grp = utf8_pack(code_point);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			esc_q    <= 1'b0;
		end else if (accept) begin
			inside_q <= inside_d;
			esc_q    <= esc_d;
		end
	end

`ifndef NO_ASSERTIONS
	// escape can only be armed inside a string
	a_esc_inside: assert property (@(posedge clk) disable iff (!arst_n)
		esc_q |-> inside_q) else $error("escape pending outside string");
`endif

endmodule

FILE: src/slu_serializer.sv
`timescale 1ns / 1ps
module slu_serializer import slu_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  grp_t          grp,
	output logic          in_ready,
	slu_out_if.source     out_ch
);

	grp_t              grp_s1;
	logic              grp_vld_s1;
	logic [1:0]        idx_q;
	logic              out_vld_q;
	kind_t             kind_q;
	logic [BYTE_W-1:0] byte_q;
	logic              last_q;

	logic load, at_last, freeing;

	assign load     = grp_vld_s1 && (!out_vld_q || out_ch.ready);
	assign at_last  = (idx_q == grp_s1.last_idx);
	assign freeing  = load && at_last;
	assign in_ready = !grp_vld_s1 || freeing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_vld_s1 <= 1'b0;
			idx_q      <= 2'd0;
			out_vld_q  <= 1'b0;
		end else begin
			if (accept && grp.emit)
				grp_vld_s1 <= 1'b1;
			else if (freeing)
				grp_vld_s1 <= 1'b0;
			if (load)
				idx_q <= at_last ? 2'd0 : idx_q + 2'd1;
			if (load)
				out_vld_q <= 1'b1;
			else if (out_ch.ready)
				out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && grp.emit)
			grp_s1 <= grp;
		if (load) begin
			kind_q <= grp_s1.kind;
			byte_q <= grp_s1.bytes[idx_q];
			last_q <= at_last;
		end
	end

	assign out_ch.valid     = out_vld_q;
	assign out_ch.kind      = kind_q;
	assign out_ch.data_byte = byte_q;
	assign out_ch.last      = last_q;

`ifndef NO_ASSERTIONS
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		grp_vld_s1 |-> idx_q <= grp_s1.last_idx) else $error("byte index past group");
	a_status_one: assert property (@(posedge clk) disable iff (!arst_n)
		(grp_vld_s1 && grp_s1.kind != KIND_CONTENT) |-> grp_s1.last_idx == 2'd0)
		else $error("status result with several bytes");
	a_group_held: assert property (@(posedge clk) disable iff (!arst_n)
		(load && !at_last) |=> grp_vld_s1) else $error("group dropped mid-sequence");
	a_idx_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!grp_vld_s1 |-> idx_q == 2'd0) else $error("stale byte index");
`endif

endmodule

FILE: src/string_literal_unescaper.sv
`timescale 1ns / 1ps
// An accepted item passes through the group register and then the output register
// before its first result shows on the output. Throughput: one item per cycle when
// each item yields at most one byte and the output is ready; an item encoding to
// several UTF-8 bytes holds the input until the single-byte output register drains
// its byte group. Reset (arst_n low, asynchronous): idle outside any string, no escape, no results.
module string_literal_unescaper import slu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	slu_in_if.sink     in_ch,
	slu_out_if.source  out_ch
);

	grp_t grp;        // decoded byte group for the current input transfer
	logic in_ready;
	logic accept;

	// An input transfer happens when the source is valid and the group register is free or
	// handing its last byte to the output register in this same cycle.
	assign in_ch.ready = in_ready;
	assign accept      = in_ch.valid && in_ready;

	// Quote / escape state machine plus UTF-8 encode, all in one pass.
	slu_decode u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.code_point   (in_ch.code_point),
		.end_of_input (in_ch.end_of_input),
		.grp          (grp)
	);

	// Group register plus output register: emits one byte per transfer,
	// with last set on the final byte of each input item.
	slu_serializer u_serializer (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.grp      (grp),
		.in_ready (in_ready),
		.out_ch   (out_ch)
	);

endmodule
